FILE: design/byte_ring_fifo_with_drop_policy_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring FIFO
// Shared property forms for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_DROP_POLICY_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_DROP_POLICY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte ring FIFO check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte ring FIFO check failed in the following cycle");

`endif

FILE: design/brf_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Sizes, command and register codes, controller states and pointer helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brf_pkg;

   localparam int DEPTH    = 256;
   localparam int MAX_READ = 64;

   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = 7;
   localparam int DATA_W   = 8;
   localparam int LEVEL_W  = 8;
   localparam int TOTAL_W  = 32;
   localparam int ADDR_W   = 3;
   localparam int CSR_W    = 32;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   // Word index of a configuration register (byte address divided by four).
   typedef enum logic {
      REG_DROP_OLDEST = 1'b0
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

   function automatic ptr_type ptr_advance(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   function automatic ptr_type ptr_level(input ptr_type wr, input ptr_type rd);
      logic [PTR_W:0] diff;
      if (wr >= rd) begin
         diff = {1'b0, wr} - {1'b0, rd};
      end else begin
         diff = (PTR_W+1)'(DEPTH) - ({1'b0, rd} - {1'b0, wr});
      end
      return diff[PTR_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] level_report(input ptr_type lvl);
      logic [LEVEL_W-1:0] r;
      if (32'(lvl) > 32'd255) begin
         r = '1;
      end else begin
         r = LEVEL_W'(lvl);
      end
      return r;
   endfunction

endpackage

FILE: design/byte_ring_fifo_with_drop_policy.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO with drop policy
// Memory-based byte FIFO with overflow policy, burst reads and traffic counters.
// ----------------------------------------------------------------------------
// Timing: a push is stored at its accepting edge. An empty or zero-count read
//   presents its one result in the cycle after acceptance; a data read presents its
//   first byte after passing the registered memory read port and the result register.
// Throughput: one push per cycle while no read is streaming; a read of data bytes
//   holds the input until its last byte is loaded, longer while results stall.
// Reset: pointers, counters, drop policy and result valid clear; memory does not.
`timescale 1ns / 1ps

module byte_ring_fifo_with_drop_policy (
   input  logic                        clock,
   input  logic                        reset,
   // Input item channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [brf_pkg::DATA_W-1:0]  req_push_byte,
   input  logic [brf_pkg::CNT_W-1:0]   req_read_count,
   // Result item channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [brf_pkg::DATA_W-1:0]  rsp_read_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_last,
   output logic [brf_pkg::LEVEL_W-1:0] rsp_fill_level,
   output logic [brf_pkg::TOTAL_W-1:0] rsp_drop_total,
   output logic [brf_pkg::TOTAL_W-1:0] rsp_in_total,
   output logic [brf_pkg::TOTAL_W-1:0] rsp_out_total,
   // Configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [brf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [brf_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [brf_pkg::CSR_W-1:0]   csr_prdata,
   output logic                        csr_pready
);

   import brf_pkg::*;

   // The byte storage. One cell is always left empty, so the ring holds at most
   // DEPTH-1 bytes and equal pointers mean empty.
   logic [DATA_W-1:0] ring_mem [DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   state_type           state_ff, state_in;
   ptr_type             wr_ptr_ff, wr_ptr_in;
   ptr_type             rd_ptr_ff, rd_ptr_in;
   logic [TOTAL_W-1:0]  drop_cnt_ff, drop_cnt_in;
   logic [TOTAL_W-1:0]  in_cnt_ff, in_cnt_in;
   logic [TOTAL_W-1:0]  out_cnt_ff, out_cnt_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic                drop_oldest_ff, drop_oldest_in;

   // Result register; it parts the result channel from the memory pipeline.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_bvalid_ff, rsp_bvalid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [TOTAL_W-1:0]  rsp_drop_ff, rsp_drop_in;
   logic [TOTAL_W-1:0]  rsp_in_ff, rsp_in_in;
   logic [TOTAL_W-1:0]  rsp_out_ff, rsp_out_in;

   logic                out_free;
   logic                req_fire;
   logic                push_fire;
   logic                read_fire;
   ptr_type             level;
   ptr_type             wr_next;
   logic [CNT_W-1:0]    read_clamped;
   logic [CNT_W-1:0]    read_n;
   logic                mem_wr_en;
   logic                mem_rd_en;
   logic                load_data;
   logic                load_empty;
   logic                csr_write;

   // ------------------------------------------------------------------------
   // Configuration port. Registers sit on word addresses; the upper address
   // bit selects the word, the byte offset bits are ignored.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      drop_oldest_in = drop_oldest_ff;
      if (csr_write && (csr_paddr[ADDR_W-1] == REG_DROP_OLDEST)) begin
         drop_oldest_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[ADDR_W-1] == REG_DROP_OLDEST) begin
         csr_prdata = {{(CSR_W-1){1'b0}}, drop_oldest_ff};
      end
   end

   // ------------------------------------------------------------------------
   // Request decode. A push needs no result slot; a read may need to place its
   // first result (the empty case) at once, so it waits for a free slot.
   // ------------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) &&
                      ((req_command == CMD_PUSH) || out_free);
   assign req_fire  = req_valid && req_ready;
   assign push_fire = req_fire && (req_command == CMD_PUSH);
   assign read_fire = req_fire && (req_command == CMD_READ);

   assign level   = ptr_level(wr_ptr_ff, rd_ptr_ff);
   assign wr_next = ptr_advance(wr_ptr_ff);

   // The request is clamped to the burst limit and then to what is stored.
   always_comb begin
      if (32'(req_read_count) > 32'(MAX_READ)) begin
         read_clamped = CNT_W'(MAX_READ);
      end else begin
         read_clamped = req_read_count;
      end
      if (32'(read_clamped) > 32'(level)) begin
         read_n = CNT_W'(level);
      end else begin
         read_n = read_clamped;
      end
   end

   // ------------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (read_fire && (read_n != '0)) begin
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            if (out_free && (remain_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath control. In the idle state a push writes the memory unless it is
   // dropped; a read issues its first memory read, or loads an empty result
   // if nothing is to be read. While streaming, each cycle in which the result
   // register can take data moves the fetched byte into it and fetches the
   // next byte, so bytes flow one per cycle. The pointer and output counter
   // advance at fetch time, so they already count a byte as it is loaded.
   // ------------------------------------------------------------------------
   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      drop_cnt_in = drop_cnt_ff;
      in_cnt_in   = in_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      remain_in   = remain_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      load_data   = 1'b0;
      load_empty  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (push_fire) begin
               in_cnt_in = in_cnt_ff + 1'b1;
               if (wr_next == rd_ptr_ff) begin
                  // Full: count the loss, then either evict the oldest byte
                  // or drop the incoming one.
                  drop_cnt_in = drop_cnt_ff + 1'b1;
                  if (drop_oldest_ff) begin
                     rd_ptr_in = ptr_advance(rd_ptr_ff);
                     mem_wr_en = 1'b1;
                     wr_ptr_in = wr_next;
                  end
               end else begin
                  mem_wr_en = 1'b1;
                  wr_ptr_in = wr_next;
               end
            end
            if (read_fire) begin
               if (read_n == '0) begin
                  load_empty = 1'b1;
               end else begin
                  mem_rd_en  = 1'b1;
                  rd_ptr_in  = ptr_advance(rd_ptr_ff);
                  out_cnt_in = out_cnt_ff + 1'b1;
                  remain_in  = read_n - 1'b1;
               end
            end
         end
         ST_STREAM: begin
            if (out_free) begin
               load_data = 1'b1;
               if (remain_ff != '0) begin
                  mem_rd_en  = 1'b1;
                  rd_ptr_in  = ptr_advance(rd_ptr_ff);
                  out_cnt_in = out_cnt_ff + 1'b1;
                  remain_in  = remain_ff - 1'b1;
               end
            end
         end
         default: begin
            remain_in = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Result register. Level and counters are sampled before this cycle's
   // updates, which for a streamed byte already include that byte's removal.
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_in_in     = rsp_in_ff;
      rsp_out_in    = rsp_out_ff;
      if (load_data || load_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = load_data ? mem_q_ff : '0;
         rsp_bvalid_in = load_data;
         rsp_last_in   = load_empty || (remain_ff == '0);
         rsp_level_in  = level_report(level);
         rsp_drop_in   = drop_cnt_ff;
         rsp_in_in     = in_cnt_ff;
         rsp_out_in    = out_cnt_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_level = rsp_level_ff;
   assign rsp_drop_total = rsp_drop_ff;
   assign rsp_in_total   = rsp_in_ff;
   assign rsp_out_total  = rsp_out_ff;

   // ------------------------------------------------------------------------
   // Byte memory: one write port, one registered read port. A write and a
   // read never target the same cycle, since each request is either a push
   // or a read and pushes are taken only in the idle state.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         ring_mem[wr_ptr_ff] <= req_push_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_q_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         drop_cnt_ff    <= '0;
         in_cnt_ff      <= '0;
         out_cnt_ff     <= '0;
         remain_ff      <= '0;
         drop_oldest_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         drop_cnt_ff    <= drop_cnt_in;
         in_cnt_ff      <= in_cnt_in;
         out_cnt_ff     <= out_cnt_in;
         remain_ff      <= remain_in;
         drop_oldest_ff <= drop_oldest_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_in_ff     <= rsp_in_in;
      rsp_out_ff    <= rsp_out_in;
   end

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------
`include "byte_ring_fifo_with_drop_policy_assert.svh"

   // A stalled stream must not fetch ahead and lose a byte.
   `BRF_ASSERT_NEXT(a_stall_holds_ptr, clock, reset, (state_ff == ST_STREAM) && rsp_valid_ff && !rsp_ready, $stable(rd_ptr_ff))

   // A result without data always closes its request.
   `BRF_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid_ff && !rsp_bvalid_ff, rsp_last_ff)

   // Every accepted push counts once toward the input total.
   `BRF_ASSERT_NEXT(a_push_counts, clock, reset, push_fire, in_cnt_ff == $past(in_cnt_ff) + 1'b1)

endmodule

FILE: sim/tb_byte_ring_fifo_with_drop_policy.sv
// ----------------------------------------------------------------------------
// Testbench for the byte ring FIFO with drop policy
// Sends pushes and read requests through the request channel under random
// gaps and result stalls. A local copy of the ring predicts every result item,
// including fill level and traffic counters. Each result is checked field by
// field. The drop policy is changed between phases over the register port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_drop_policy;

   import brf_pkg::*;

   // The run is cut off here.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Quiet cycles allowed before a register write and at the end. This covers
   // the memory read latency and a push still being written.
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct {
      cmd_type              cmd;
      logic [DATA_W-1:0]    data;
      logic [CNT_W-1:0]     count;
   } fifo_req_type;

   typedef struct {
      logic [DATA_W-1:0]    read_byte;
      logic                 byte_valid;
      logic                 last;
      logic [LEVEL_W-1:0]   fill_level;
      logic [TOTAL_W-1:0]   drop_total;
      logic [TOTAL_W-1:0]   in_total;
      logic [TOTAL_W-1:0]   out_total;
   } fifo_rsp_type;

   // Every input gets a known value from time zero.
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_command    = 1'b0;
   logic [DATA_W-1:0]    req_push_byte  = '0;
   logic [CNT_W-1:0]     req_read_count = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [DATA_W-1:0]    rsp_read_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_last;
   logic [LEVEL_W-1:0]   rsp_fill_level;
   logic [TOTAL_W-1:0]   rsp_drop_total;
   logic [TOTAL_W-1:0]   rsp_in_total;
   logic [TOTAL_W-1:0]   rsp_out_total;
   logic                 csr_psel       = 1'b0;
   logic                 csr_penable    = 1'b0;
   logic                 csr_pwrite     = 1'b0;
   logic [ADDR_W-1:0]    csr_paddr      = '0;
   logic [CSR_W-1:0]     csr_pwdata     = '0;
   logic [CSR_W-1:0]     csr_prdata;
   logic                 csr_pready;

   byte_ring_fifo_with_drop_policy DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_push_byte  (req_push_byte),
      .req_read_count (req_read_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_fill_level (rsp_fill_level),
      .rsp_drop_total (rsp_drop_total),
      .rsp_in_total   (rsp_in_total),
      .rsp_out_total  (rsp_out_total),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Local copy of the ring. It is updated when a request item is accepted.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0]    ring_bytes [0:DEPTH-1];
   ptr_type              head_ptr  = '0;   // next cell to write
   ptr_type              tail_ptr  = '0;   // oldest stored byte
   logic [TOTAL_W-1:0]   dropped_bytes   = '0;
   logic [TOTAL_W-1:0]   offered_bytes   = '0;
   logic [TOTAL_W-1:0]   delivered_bytes = '0;
   logic                 overwrite_oldest = 1'b0;

   fifo_req_type         pending_req_q [$];
   fifo_rsp_type         expected_rsp_q [$];
   int unsigned          error_count = 0;
   int unsigned          cycle_count = 0;

   function automatic ptr_type ring_next(input ptr_type p);
      if (int'(p) == DEPTH - 1) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   function automatic int unsigned ring_fill();
      if (head_ptr >= tail_ptr) begin
         return int'(head_ptr) - int'(tail_ptr);
      end
      return DEPTH - (int'(tail_ptr) - int'(head_ptr));
   endfunction

   // Queues one result item. The level and the counters are taken as they
   // stand after the byte has left the ring. A level above 255 saturates.
   function automatic void queue_result(input logic [DATA_W-1:0] b, input logic valid,
                                        input logic fin);
      fifo_rsp_type r;
      int unsigned lvl;
      lvl          = ring_fill();
      r.read_byte  = b;
      r.byte_valid = valid;
      r.last       = fin;
      r.fill_level = (lvl > 255) ? 8'hFF : LEVEL_W'(lvl);
      r.drop_total = dropped_bytes;
      r.in_total   = offered_bytes;
      r.out_total  = delivered_bytes;
      expected_rsp_q.push_back(r);
   endfunction

   function automatic void predict_fifo(input fifo_req_type it);
      ptr_type     nxt;
      int unsigned take;
      if (it.cmd == CMD_PUSH) begin
         nxt = ring_next(head_ptr);
         offered_bytes++;
         if (nxt == tail_ptr) begin
            // The ring is full. One byte is lost, and the policy decides which.
            dropped_bytes++;
            if (overwrite_oldest) begin
               tail_ptr = ring_next(tail_ptr);
               ring_bytes[head_ptr] = it.data;
               head_ptr = nxt;
            end
         end else begin
            ring_bytes[head_ptr] = it.data;
            head_ptr = nxt;
         end
      end else begin
         take = it.count;
         if (take > MAX_READ) begin
            take = MAX_READ;
         end
         if (take > ring_fill()) begin
            take = ring_fill();
         end
         if (take == 0) begin
            // An empty ring or a zero count gives one result with no data.
            queue_result('0, 1'b0, 1'b1);
         end else begin
            for (int unsigned i = 0; i < take; i++) begin
               nxt = tail_ptr;
               tail_ptr = ring_next(tail_ptr);
               delivered_bytes++;
               queue_result(ring_bytes[nxt], 1'b1, (i + 1 == take));
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Gap lengths for both channels: mostly none or short, a few long, and
   // now and then a calm stretch with no gaps at all.
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap(inout int unsigned calm_left);
      int unsigned roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_left = $urandom_range(16, 48);
         return 0;
      end
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 30);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver. It holds an item until it is accepted, then waits out
   // a random gap before it presents the next one from the pending queue.
   // The prediction runs at the edge where the item is accepted.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      fifo_req_type       nxt;
      static int unsigned send_gap  = 0;
      static int unsigned send_calm = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_fifo('{cmd: cmd_type'(req_command), data: req_push_byte,
                           count: req_read_count});
         end
         // A presented item that is not yet taken stays on the channel.
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
               nxt = pending_req_q.pop_front();
               req_valid      <= 1'b1;
               req_command    <= nxt.cmd;
               req_push_byte  <= nxt.data;
               req_read_count <= nxt.count;
               send_gap = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor. It checks each accepted result item against the oldest
   // prediction and drops rsp_ready for random stretches.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_results
      fifo_rsp_type       want;
      static int unsigned stall_left = 0;
      static int unsigned stall_calm = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result item arrived with none predicted");
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("read_byte",  rsp_read_byte,  want.read_byte);
               check_field("byte_valid", rsp_byte_valid, want.byte_valid);
               check_field("last",       rsp_last,       want.last);
               check_field("fill_level", rsp_fill_level, want.fill_level);
               check_field("drop_total", rsp_drop_total, want.drop_total);
               check_field("in_total",   rsp_in_total,   want.in_total);
               check_field("out_total",  rsp_out_total,  want.out_total);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall_left = pick_gap(stall_calm);
            end
         end
      end
   end

   // A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL byte_ring_fifo_with_drop_policy");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers. The field that the command ignores still gets random
   // bits, so every bit of every field toggles.
   // ---------------------------------------------------------------------
   function automatic void add_push(input logic [DATA_W-1:0] b);
      pending_req_q.push_back('{cmd: CMD_PUSH, data: b,
                                count: CNT_W'($urandom_range(0, 127))});
   endfunction

   function automatic void add_read(input logic [CNT_W-1:0] n);
      pending_req_q.push_back('{cmd: CMD_READ, data: DATA_W'($urandom_range(0, 255)),
                                count: n});
   endfunction

   // Read counts are mostly small. Some reach MAX_READ, and some exceed it
   // up to the top of the field.
   function automatic logic [CNT_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return CNT_W'($urandom_range(0, 4));
      if (roll < 70) return CNT_W'($urandom_range(5, 20));
      if (roll < 90) return CNT_W'($urandom_range(21, 64));
      return CNT_W'($urandom_range(65, 127));
   endfunction

   // A random mix of exactly n items. Short push bursts raise the level so
   // that reads have something to return.
   function automatic void add_random_mix(input int unsigned n);
      int unsigned left;
      int unsigned burst;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 60) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : 1;
            if (burst > left) begin
               burst = left;
            end
            repeat (burst) add_push(DATA_W'($urandom_range(0, 255)));
            left -= burst;
         end else begin
            add_read(pick_count());
            left--;
         end
      end
   endfunction

   // Waits until every item has been sent and every result has arrived,
   // then lets the block settle. Polling at the falling edge keeps clear
   // of the edge where the driver and the monitor work.
   task automatic wait_quiet();
      do begin
         @(negedge clock);
      end while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register transfer: a setup cycle, then an access cycle that ends at
   // the edge where pready is seen high.
   task automatic csr_transfer(input logic wr, input reg_index_type idx,
                               input logic [CSR_W-1:0] wdata,
                               output logic [CSR_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_W'(4 * int'(idx));
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes the drop policy, reads it back, and updates the local copy.
   task automatic set_drop_policy(input logic oldest);
      logic [CSR_W-1:0] rd;
      csr_transfer(1'b1, REG_DROP_OLDEST, CSR_W'(oldest), rd);
      overwrite_oldest = oldest;
      csr_transfer(1'b0, REG_DROP_OLDEST, '0, rd);
      if (rd[0] !== oldest) begin
         report_mismatch($sformatf("drop policy reads back %0b, expected %0b", rd[0], oldest));
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [CSR_W-1:0] rd;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The policy must come out of reset as discard-incoming.
      csr_transfer(1'b0, REG_DROP_OLDEST, '0, rd);
      if (rd[0] !== 1'b0) begin
         report_mismatch("drop policy is not zero after reset");
      end
      set_drop_policy(1'b0);

      // Directed part: reads of an empty ring, push data extremes, a zero
      // count while data is held, reads limited by the level, and a count
      // above MAX_READ.
      @(negedge clock);
      add_read(CNT_W'(0));
      add_read(CNT_W'(7));
      add_read(CNT_W'(127));
      add_push(8'h00);
      add_push(8'hFF);
      add_push(8'h55);
      add_push(8'hAA);
      add_push(8'h01);
      add_push(8'h80);
      add_read(CNT_W'(0));
      add_read(CNT_W'(1));
      add_read(CNT_W'(2));
      add_read(CNT_W'(127));
      add_push(8'h7F);
      add_push(8'hFE);
      add_read(CNT_W'(MAX_READ));
      add_push(8'h3C);
      add_push(8'hC3);
      add_push(8'h99);
      add_read(CNT_W'(MAX_READ + 1));
      wait_quiet();

      // Random traffic under discard-incoming.
      @(negedge clock);
      add_random_mix(28);
      wait_quiet();

      // Random traffic under overwrite-oldest.
      set_drop_policy(1'b1);
      @(negedge clock);
      add_random_mix(28);
      wait_quiet();

      set_drop_policy(1'b0);
      @(negedge clock);
      add_random_mix(27);
      wait_quiet();

      set_drop_policy(1'b1);
      @(negedge clock);
      add_random_mix(27);
      wait_quiet();

      if (error_count == 0) begin
         $display("PASS byte_ring_fifo_with_drop_policy");
      end else begin
         $display("FAIL byte_ring_fifo_with_drop_policy");
      end
      $finish;
   end

endmodule
